// ===== sv/rle16_pkg.sv =====
// Shared types and constants for the 16-bit run-length frame decoder.
// No dependencies; every other file refers to this package by scoped names.
package rle16_pkg;

  // Fixed field widths of the stream and span channels
  localparam int WORD_W     = 16;
  localparam int IDX_W      = 20;
  localparam int LEN_W      = 15;
  localparam int COL_W      = 16;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

  // Stream word coding
  localparam logic [WORD_W-1:0] FILL_VALUE = 16'h8000;
  localparam logic [LEN_W-1:0]  RUN_MASK   = 15'h7fff;

  // Work handed from the classifier to the span engine
  typedef enum logic [1:0] {
    CMD_FILL,
    CMD_LIT_PIX,
    CMD_LIT_START
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              last;   // final literal pixel of its run
    logic [WORD_W-1:0] word;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/rle16_if.sv =====
// Channel interfaces: stream word input, span output and register writes.
// Depends on rle16_pkg for field widths.
interface rle16_in_if;
  logic                           valid;
  logic                           ready;
  logic [rle16_pkg::WORD_W-1:0]   data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface rle16_out_if;
  logic                           valid;
  logic                           ready;
  logic [rle16_pkg::IDX_W-1:0]    start_index;
  logic [rle16_pkg::LEN_W-1:0]    span_length;
  logic [rle16_pkg::WORD_W-1:0]   pixel_value;
  logic                           is_fill;
  logic                           frame_end;
  modport source (output valid, output start_index, output span_length,
                  output pixel_value, output is_fill, output frame_end, input ready);
  modport sink   (input valid, input start_index, input span_length,
                  input pixel_value, input is_fill, input frame_end, output ready);
endinterface

interface rle16_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rle16_pkg::CFG_IDX_W-1:0]   index;
  logic [rle16_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/rle16_front.sv =====
// Front end: accepts stream words, tracks the literal count, classifies beats.
// Depends on rle16_pkg (cmd_t, q_stat_t, constants).
module rle16_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rle16_pkg::WORD_W-1:0]  in_data_word,
  input  rle16_pkg::q_stat_t            q_stat,
  output logic                          push,
  output rle16_pkg::cmd_t               cmd
);

  logic [rle16_pkg::LEN_W-1:0] left_r;
  logic [rle16_pkg::LEN_W-1:0] left_nxt;
  logic [rle16_pkg::LEN_W-1:0] run_len;
  logic                        accept;
  logic                        emit;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign run_len  = in_data_word[rle16_pkg::LEN_W-1:0] & rle16_pkg::RUN_MASK;

  // Classify the beat: literal pixel, fill, literal header or nothing
  always_comb begin
    emit      = 1'b0;
    left_nxt  = left_r;
    cmd.kind  = rle16_pkg::CMD_FILL;
    cmd.last  = 1'b0;
    cmd.word  = in_data_word;
    if (left_r != '0) begin
      emit     = 1'b1;
      cmd.kind = rle16_pkg::CMD_LIT_PIX;
      cmd.last = (left_r == rle16_pkg::LEN_W'(1));
      left_nxt = left_r - rle16_pkg::LEN_W'(1);
    end else if (in_data_word[rle16_pkg::WORD_W-1]) begin
      emit     = (run_len != '0);
      cmd.kind = rle16_pkg::CMD_FILL;
    end else if (in_data_word != '0) begin
      emit     = 1'b1;
      cmd.kind = rle16_pkg::CMD_LIT_START;
      left_nxt = run_len;
    end
  end

  assign push = accept && emit;

  // Remaining literal count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (accept) begin
      left_r <= left_nxt;
    end
  end

endmodule

// ===== sv/rle16_fifo.sv =====
// Small command queue between the classifier and the span engine.
// Depends on rle16_pkg (cmd_t, q_stat_t).
module rle16_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rle16_pkg::cmd_t    push_cmd,
  input  logic               pop,
  output rle16_pkg::cmd_t    head_cmd,
  output rle16_pkg::q_stat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rle16_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== sv/rle16_back.sv =====
// Span engine: keeps column, row and literal position, clips spans to the
// frame and holds the output register. Depends on rle16_pkg.
module rle16_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // register writes
  input  logic                              cfg_we,
  input  logic [rle16_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rle16_pkg::CFG_DATA_W-1:0]  cfg_data,
  // command queue
  input  rle16_pkg::q_stat_t                q_stat,
  input  rle16_pkg::cmd_t                   cmd,
  output logic                              pop,
  // span output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rle16_pkg::IDX_W-1:0]       out_start_index,
  output logic [rle16_pkg::LEN_W-1:0]       out_span_length,
  output logic [rle16_pkg::WORD_W-1:0]      out_pixel_value,
  output logic                              out_is_fill,
  output logic                              out_frame_end
);

  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int MX1   = (POS_W > rle16_pkg::COL_W) ? POS_W : rle16_pkg::COL_W;
  localparam int SUM_W = ((MX1 > rle16_pkg::IDX_W) ? MX1 : rle16_pkg::IDX_W) + 1;
  localparam int COL_W = rle16_pkg::COL_W;
  localparam int LEN_W = rle16_pkg::LEN_W;
  localparam int IDX_W = rle16_pkg::IDX_W;

  // Clamp a written width or height into 1..max
  function automatic logic [WID_W-1:0] clamp_w(input logic [rle16_pkg::CFG_DATA_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v == '0) begin
      r = WID_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      r = WID_W'(MAX_WIDTH);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_h(input logic [rle16_pkg::CFG_DATA_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = ROW_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = ROW_W'(MAX_HEIGHT);
    end else begin
      r = ROW_W'(v);
    end
    return r;
  endfunction

  // Configuration and position state
  logic [WID_W-1:0]  eff_w_r;
  logic [ROW_W-1:0]  eff_h_r;
  logic [POS_W-1:0]  total_r;
  logic [POS_W-1:0]  row_base_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [IDX_W-1:0]  lit_pos_r;

  // Output register
  logic              out_valid_r;
  logic [IDX_W-1:0]  res_start_r;
  logic [LEN_W-1:0]  res_len_r;
  logic [rle16_pkg::WORD_W-1:0] res_val_r;
  logic              res_fill_r;
  logic              res_fe_r;

  // Datapath
  logic [WID_W-1:0]  w_new;
  logic [ROW_W-1:0]  h_new;
  logic [POS_W-1:0]  w_new_x;
  logic [POS_W-1:0]  h_new_x;
  logic [POS_W-1:0]  row_x;
  logic [SUM_W-1:0]  start_sum;
  logic [SUM_W-1:0]  total_x;
  logic [SUM_W-1:0]  remain;
  logic [LEN_W-1:0]  run_len;
  logic [COL_W-1:0]  col_step;
  logic [ROW_W-1:0]  row_inc;
  logic              close_req;
  logic              closes;
  logic              frame_wrap;
  logic              fill_in;
  logic              lit_in;
  logic              produce;
  logic              load;
  logic [IDX_W-1:0]  res_start;
  logic [LEN_W-1:0]  res_len;
  logic              res_fill;

  // New register values for a write
  assign w_new   = (cfg_index == rle16_pkg::REG_FRAME_WIDTH)  ? clamp_w(cfg_data) : eff_w_r;
  assign h_new   = (cfg_index == rle16_pkg::REG_FRAME_HEIGHT) ? clamp_h(cfg_data) : eff_h_r;
  assign w_new_x = POS_W'(w_new);
  assign h_new_x = POS_W'(h_new);
  assign row_x   = POS_W'(row_r);

  // Position arithmetic for the command at the queue head
  assign run_len   = cmd.word[LEN_W-1:0] & rle16_pkg::RUN_MASK;
  assign start_sum = SUM_W'(row_base_r) + SUM_W'(col_r);
  assign total_x   = SUM_W'(total_r);
  assign remain    = total_x - start_sum;
  assign fill_in   = (start_sum < total_x);
  assign lit_in    = (SUM_W'(lit_pos_r) < total_x);
  assign col_step  = (cmd.kind == rle16_pkg::CMD_FILL) ? col_r + COL_W'(run_len)
                                                       : col_r + COL_W'(1);
  assign close_req = (cmd.kind == rle16_pkg::CMD_FILL) ||
                     ((cmd.kind == rle16_pkg::CMD_LIT_PIX) && cmd.last);
  assign closes     = close_req && (col_step >= COL_W'(eff_w_r));
  assign row_inc    = row_r + ROW_W'(1);
  assign frame_wrap = (row_inc >= eff_h_r);

  // Result selection
  always_comb begin
    produce   = 1'b0;
    res_start = lit_pos_r;
    res_len   = LEN_W'(1);
    res_fill  = 1'b0;
    unique case (cmd.kind)
      rle16_pkg::CMD_FILL: begin
        produce   = fill_in;
        res_start = start_sum[IDX_W-1:0];
        res_len   = (SUM_W'(run_len) < remain) ? run_len : remain[LEN_W-1:0];
        res_fill  = 1'b1;
      end
      rle16_pkg::CMD_LIT_PIX: begin
        produce = lit_in;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  // A register write takes the cycle; the queue head waits
  assign pop  = !q_stat.empty && (!out_valid_r || out_ready) && !cfg_we;
  assign load = pop && produce;

  // Register file and position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r    <= WID_W'(clamp_w(rle16_pkg::WIDTH_RESET));
      eff_h_r    <= ROW_W'(clamp_h(rle16_pkg::HEIGHT_RESET));
      total_r    <= POS_W'(clamp_w(rle16_pkg::WIDTH_RESET)) *
                    POS_W'(clamp_h(rle16_pkg::HEIGHT_RESET));
      row_base_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      lit_pos_r  <= '0;
    end else if (cfg_we) begin
      eff_w_r    <= w_new;
      eff_h_r    <= h_new;
      total_r    <= w_new_x * h_new_x;
      row_base_r <= row_x * w_new_x;
    end else if (pop) begin
      if (cmd.kind == rle16_pkg::CMD_LIT_START) begin
        lit_pos_r <= start_sum[IDX_W-1:0];
      end else begin
        if (cmd.kind == rle16_pkg::CMD_LIT_PIX) begin
          lit_pos_r <= lit_pos_r + IDX_W'(1);
        end
        if (closes) begin
          col_r <= '0;
          if (frame_wrap) begin
            row_r      <= '0;
            row_base_r <= '0;
          end else begin
            row_r      <= row_inc;
            row_base_r <= row_base_r + POS_W'(eff_w_r);
          end
        end else begin
          col_r <= col_step;
        end
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_start_r <= res_start;
      res_len_r   <= res_len;
      res_val_r   <= res_fill ? rle16_pkg::FILL_VALUE : cmd.word;
      res_fill_r  <= res_fill;
      res_fe_r    <= closes && frame_wrap;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_start_index = res_start_r;
  assign out_span_length = res_len_r;
  assign out_pixel_value = res_val_r;
  assign out_is_fill     = res_fill_r;
  assign out_frame_end   = res_fe_r;

endmodule

// ===== sv/rle16_frame_decoder.sv =====
// Top level of the 16-bit run-length frame decoder: classifier, queue, span engine.
// Depends on rle16_pkg, rle16_if, rle16_front, rle16_fifo and rle16_back.
//
//   channel  direction  handshake      beat
//   in_s     in         valid/ready    one 16-bit stream word
//   out_s    out        valid/ready    one span: start, length, value, flags
//   cfg_s    in         valid/ready    register index and 11-bit data
//
// Throughput is one stream word per cycle while in_s.ready is high; a span reaches
// out_s through the queue write and then the span engine's output register.
// The span engine's column/row update loop sets the rate. Synchronous
// active-low reset clears positions and loads 640 x 480.
// An output stall fills the output register, then the two-entry queue, and
// then drops in_s.ready; cfg_s.ready is always high.
module rle16_frame_decoder #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  rle16_in_if.sink    in_s,
  rle16_out_if.source out_s,
  rle16_cfg_if.sink   cfg_s
);

  rle16_pkg::q_stat_t q_stat;
  rle16_pkg::cmd_t    push_cmd;
  rle16_pkg::cmd_t    head_cmd;
  logic               push;
  logic               pop;

  assign cfg_s.ready = 1'b1;

  // Classifier
  rle16_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_s.valid),
    .in_ready     (in_s.ready),
    .in_data_word (in_s.data_word),
    .q_stat       (q_stat),
    .push         (push),
    .cmd          (push_cmd)
  );

  // Command queue
  rle16_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // Span engine
  rle16_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_s.valid && cfg_s.ready),
    .cfg_index       (cfg_s.index),
    .cfg_data        (cfg_s.data),
    .q_stat          (q_stat),
    .cmd             (head_cmd),
    .pop             (pop),
    .out_valid       (out_s.valid),
    .out_ready       (out_s.ready),
    .out_start_index (out_s.start_index),
    .out_span_length (out_s.span_length),
    .out_pixel_value (out_s.pixel_value),
    .out_is_fill     (out_s.is_fill),
    .out_frame_end   (out_s.frame_end)
  );

  // The span engine never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("span engine popped an empty queue");

  // A span never has zero length
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> out_s.span_length != '0)
    else $error("zero-length span");

  // Literal spans cover exactly one pixel
  a_lit_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && !out_s.is_fill |-> out_s.span_length == rle16_pkg::LEN_W'(1))
    else $error("literal span longer than one pixel");

  // Fill spans carry the transparent value
  a_fill_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.is_fill |-> out_s.pixel_value == rle16_pkg::FILL_VALUE)
    else $error("fill span with wrong value");

endmodule
